/* hw/rtl/rlcs_pkg.sv */
// ----------------------------------------------------------------------------
// rlcs_pkg
// Shared types and constants for the RGB LED chain serializer.
// ----------------------------------------------------------------------------
package rlcs_pkg;

  // Chain geometry
  localparam int unsigned MaxLedsDefault = 16;
  localparam int unsigned PixelSlots     = 16;  // reachable by a 4-bit pixel index
  localparam int unsigned BitsPerLed     = 24;
  localparam int unsigned QueueDepth     = 2;

  // Register reset values
  localparam logic [4:0] LedCountReset = 5'd0;
  localparam logic [5:0] PeriodReset   = 6'd30;
  localparam logic [5:0] OneHighReset  = 6'd17;
  localparam logic [5:0] ZeroHighReset = 6'd9;

  // Configuration register indexes
  localparam logic [1:0] RegLedCount = 2'd0;
  localparam logic [1:0] RegPeriod   = 2'd1;
  localparam logic [1:0] RegOneHigh  = 2'd2;
  localparam logic [1:0] RegZeroHigh = 2'd3;

  // Command codes carried in the input word
  localparam logic [1:0] CmdSetPixel = 2'd0;
  localparam logic [1:0] CmdSend     = 2'd1;
  localparam logic [1:0] CmdTick     = 2'd2;
  localparam logic [1:0] CmdNop      = 2'd3;

  // Input word
  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic done_res;
    logic rejected;
  } out_word_t;

  // Decoded operation passed from front to back
  typedef enum logic [1:0] {
    OpSetPixel,
    OpSend,
    OpTick,
    OpNop
  } op_kind_e;

  typedef struct packed {
    op_kind_e    kind;
    logic [3:0]  pixel_index;
    logic [23:0] color;        // {green, red, blue}
  } op_t;

endpackage

/* hw/rtl/rgb_led_chain_serializer_top.sv */
// Path: an accepted input word enters the operation queue, and the back
// end registers its result word. Throughput: one word per cycle while
// the output is not stalled, set by the execute step; a two-entry queue
// decouples it. Reset: asynchronous; clears the pixel store, transfer
// state, queue and result valid; loads defaults (30/17/9 ticks, no LEDs).
// ----------------------------------------------------------------------------
// rgb_led_chain_serializer_top
// One-wire RGB LED chain driver: front decode and queue, back execute.
// ----------------------------------------------------------------------------
module rgb_led_chain_serializer_top #(
  parameter int unsigned MAX_LEDS = rlcs_pkg::MaxLedsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [5:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rlcs_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rlcs_pkg::out_word_t out_word_o
);
  import rlcs_pkg::*;

  logic op_valid;
  logic op_pop;
  op_t  op;

  // Decode and queue
  rlcs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  // Execute and drive results
  rlcs_back #(
    .MAX_LEDS (MAX_LEDS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .op_valid_i  (op_valid),
    .op_i        (op),
    .op_pop_o    (op_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

/* hw/rtl/rlcs_front.sv */
// ----------------------------------------------------------------------------
// rlcs_front
// Accepts input words, decodes the command and queues the operation.
// ----------------------------------------------------------------------------
module rlcs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rlcs_pkg::in_word_t in_word_i,
  output logic             op_valid_o,
  output rlcs_pkg::op_t    op_o,
  input  logic             op_pop_i
);
  import rlcs_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  op_t             queue_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  op_t             op_dec;
  logic            push, pop;

  // Decode the command into an operation
  always_comb begin
    op_dec.pixel_index = in_word_i.pixel_index;
    op_dec.color       = {in_word_i.green, in_word_i.red, in_word_i.blue};
    unique case (in_word_i.cmd)
      CmdSetPixel: op_dec.kind = OpSetPixel;
      CmdSend:     op_dec.kind = OpSend;
      CmdTick:     op_dec.kind = OpTick;
      default:     op_dec.kind = OpNop;
    endcase
  end

  assign in_stall_o = (count_q == CntW'(QueueDepth));
  assign op_valid_o = (count_q != '0);
  assign op_o       = queue_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = op_pop_i && op_valid_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= op_dec;
    end
  end

endmodule

/* hw/rtl/rlcs_back.sv */
// ----------------------------------------------------------------------------
// rlcs_back
// Executes queued operations: pixel store, bit waveform timing and the
// registered result word.
// ----------------------------------------------------------------------------
module rlcs_back #(
  parameter int unsigned MAX_LEDS = rlcs_pkg::MaxLedsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [5:0]         cfg_data_i,
  input  logic               op_valid_i,
  input  rlcs_pkg::op_t      op_i,
  output logic               op_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rlcs_pkg::out_word_t out_word_o
);
  import rlcs_pkg::*;

  localparam int unsigned StoreDepth = (MAX_LEDS < PixelSlots) ? MAX_LEDS : PixelSlots;
  localparam int unsigned IdxW       = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned UsedCap    = (MAX_LEDS > 31) ? 31 : MAX_LEDS;

  // Configuration registers
  logic [4:0] led_count_q;
  logic [5:0] period_q, one_high_q, zero_high_q;

  // Transfer state
  logic [23:0] store_q [StoreDepth];
  logic        sending_q, sending_d;
  logic [4:0]  led_q, led_d;
  logic [4:0]  bit_q, bit_d;
  logic [5:0]  tick_q, tick_d;

  // Result register
  logic      out_valid_q;
  out_word_t out_word_q, out_word_d;

  logic [4:0]  used_leds;
  logic [23:0] pix;
  logic        pix_bit;
  logic [5:0]  high_ticks;
  logic [6:0]  tick_inc;
  logic [5:0]  bit_inc;
  logic [5:0]  led_inc;
  logic        fire;
  logic        wr_en;

  assign fire     = op_valid_i && (!out_valid_q || !out_stall_i);
  assign op_pop_o = fire;

  assign used_leds = (led_count_q > 5'(UsedCap)) ? 5'(UsedCap) : led_count_q;

  // Current bit and its high time
  assign pix        = (led_q < 5'(StoreDepth)) ? store_q[led_q[IdxW-1:0]] : '0;
  assign pix_bit    = pix[5'(BitsPerLed - 1) - bit_q];
  assign high_ticks = pix_bit ? one_high_q : zero_high_q;
  assign tick_inc   = {1'b0, tick_q} + 7'd1;
  assign bit_inc    = {1'b0, bit_q} + 6'd1;
  assign led_inc    = {1'b0, led_q} + 6'd1;

  // Execute one operation
  always_comb begin
    sending_d  = sending_q;
    led_d      = led_q;
    bit_d      = bit_q;
    tick_d     = tick_q;
    wr_en      = 1'b0;
    out_word_d = '0;
    unique case (op_i.kind)
      OpSetPixel: begin
        if (sending_q || ({1'b0, op_i.pixel_index} >= used_leds)
            || ({1'b0, op_i.pixel_index} >= 5'(StoreDepth))) begin
          out_word_d.rejected = 1'b1;
        end else begin
          wr_en = 1'b1;
        end
      end
      OpSend: begin
        if (sending_q) begin
          out_word_d.rejected = 1'b1;
        end else if (used_leds != '0) begin
          sending_d = 1'b1;
          led_d     = '0;
          bit_d     = '0;
          tick_d    = '0;
        end
      end
      OpTick: begin
        if (sending_q) begin
          out_word_d.line_level = (tick_q < high_ticks);
          tick_d = tick_inc[5:0];
          if (tick_inc >= {1'b0, period_q}) begin
            tick_d = '0;
            bit_d  = bit_inc[4:0];
            if (bit_inc >= 6'(BitsPerLed)) begin
              bit_d = '0;
              led_d = led_inc[4:0];
              if (led_inc >= {1'b0, used_leds}) begin
                sending_d           = 1'b0;
                led_d               = '0;
                out_word_d.done_res = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    out_word_d.busy_res = sending_d;
  end

  // State, pixel store and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_count_q <= LedCountReset;
      period_q    <= PeriodReset;
      one_high_q  <= OneHighReset;
      zero_high_q <= ZeroHighReset;
      sending_q   <= 1'b0;
      led_q       <= '0;
      bit_q       <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < StoreDepth; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegLedCount: led_count_q <= cfg_data_i[4:0];
          RegPeriod:   period_q    <= cfg_data_i;
          RegOneHigh:  one_high_q  <= cfg_data_i;
          RegZeroHigh: zero_high_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (fire) begin
        sending_q <= sending_d;
        led_q     <= led_d;
        bit_q     <= bit_d;
        tick_q    <= tick_d;
        if (wr_en) begin
          store_q[op_i.pixel_index[IdxW-1:0]] <= op_i.color;
        end
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
